>>> sv/calibrated_compass_heading_defines.svh
// Assertion macros for the calibrated compass heading block.
// Used by calibrated_compass_heading.sv; no other dependencies.
`ifndef CALIBRATED_COMPASS_HEADING_DEFINES_SVH
`define CALIBRATED_COMPASS_HEADING_DEFINES_SVH

`ifndef SYNTHESIS
`define CCH_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");
`define CCH_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define CCH_ASSERT_NOW(label, ante, cons)
`define CCH_ASSERT_NEXT(label, ante, cons)
`endif

`endif

>>> sv/cch_pkg.sv
// Shared constants and the CORDIC arctangent table for the compass heading block.
// No dependencies; imported by calibrated_compass_heading.
`timescale 1ns / 1ps

package cch_pkg;

  localparam int ACC_FRAC  = 16;
  localparam int IN_SCALE  = 24;
  localparam int TABLE_LEN = 24;
  localparam int COR_W     = 18;
  localparam int ZW        = 26;
  localparam int CFG_W     = 16;
  localparam int IDX_W     = 3;

  localparam logic [IDX_W-1:0] CFG_X_MIN = 3'd0;
  localparam logic [IDX_W-1:0] CFG_X_MAX = 3'd1;
  localparam logic [IDX_W-1:0] CFG_Y_MIN = 3'd2;
  localparam logic [IDX_W-1:0] CFG_Y_MAX = 3'd3;

  localparam logic signed [CFG_W-1:0] X_MIN_RST = -16'sd113;
  localparam logic signed [CFG_W-1:0] X_MAX_RST = 16'sd1210;
  localparam logic signed [CFG_W-1:0] Y_MIN_RST = -16'sd1872;
  localparam logic signed [CFG_W-1:0] Y_MAX_RST = 16'sd23;

  localparam logic signed [ZW-1:0] Z_FULL = ZW'(360 * 65536);
  localparam logic signed [ZW-1:0] Z_HALF = ZW'(180 * 65536);

  function automatic logic signed [ZW-1:0] atan_deg_q16(input int i);
    logic signed [ZW-1:0] r;
    case (i)
      0:       r = 26'sd2949120;
      1:       r = 26'sd1740967;
      2:       r = 26'sd919879;
      3:       r = 26'sd466945;
      4:       r = 26'sd234379;
      5:       r = 26'sd117304;
      6:       r = 26'sd58666;
      7:       r = 26'sd29335;
      8:       r = 26'sd14668;
      9:       r = 26'sd7334;
      10:      r = 26'sd3667;
      11:      r = 26'sd1833;
      12:      r = 26'sd917;
      13:      r = 26'sd458;
      14:      r = 26'sd229;
      15:      r = 26'sd115;
      16:      r = 26'sd57;
      17:      r = 26'sd29;
      18:      r = 26'sd14;
      19:      r = 26'sd7;
      20:      r = 26'sd4;
      21:      r = 26'sd2;
      22:      r = 26'sd1;
      default: r = 26'sd0;
    endcase
    return r;
  endfunction

endpackage

>>> sv/calibrated_compass_heading.sv
// Hard-iron corrected compass heading using a fully unrolled CORDIC pipeline.
// Depends on cch_pkg and calibrated_compass_heading_defines.svh.
// Stages: input, offset, half plane, CORDIC (one per iteration, max 24), wrap, output.
// Throughput: one transaction per cycle while out_ready does not stall the pipeline.
// Each stage holds its item independently, so bubbles collapse under a stall.
// Synchronous active-low reset clears all valid bits and loads the calibration defaults.
`timescale 1ns / 1ps
`include "calibrated_compass_heading_defines.svh"

module calibrated_compass_heading import cch_pkg::*; #(
  parameter int CORDIC_ITERATIONS   = 16,
  parameter int ANGLE_FRACTION_BITS = 6
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_valid,
  output logic                    in_ready,
  input  logic                    in_data_ready,
  input  logic signed [15:0]      in_x_raw,
  input  logic signed [15:0]      in_y_raw,
  output logic                    out_valid,
  input  logic                    out_ready,
  output logic [14:0]             out_heading,
  input  logic                    cfg_we,
  input  logic [IDX_W-1:0]        cfg_index,
  input  logic [CFG_W-1:0]        cfg_data
);

  localparam int NI      = (CORDIC_ITERATIONS > TABLE_LEN) ? TABLE_LEN : CORDIC_ITERATIONS;
  localparam int NS      = NI + 5;
  localparam int ST_WRAP = NI + 3;
  localparam int ST_OUT  = NI + 4;
  localparam int SH      = ACC_FRAC - ANGLE_FRACTION_BITS;
  localparam int W       = COR_W + IN_SCALE + 3;
  localparam int HW      = ZW + 1;
  localparam logic [HW-1:0] H_FULL  = HW'(360 << ANGLE_FRACTION_BITS);
  localparam logic [HW-1:0] H_ROUND = HW'(1 << (SH - 1));

  logic signed [CFG_W-1:0] x_min_r, x_max_r, y_min_r, y_max_r;

  logic [NS-1:0] valid_r;
  logic [NS-1:0] adv;

  logic signed [15:0] s0_x_r, s0_y_r;
  logic signed [16:0] s0_offx_r, s0_offy_r;
  logic signed [16:0] offx_sum, offy_sum, offx_nxt, offy_nxt;

  logic signed [COR_W-1:0] s1_cx_r, s1_cy_r, s1_cx_nxt, s1_cy_nxt;
  logic                    s1_zero_r;

  logic signed [W-1:0]  cx_r [0:NI];
  logic signed [W-1:0]  cy_r [0:NI];
  logic signed [ZW-1:0] cz_r [0:NI];
  logic                 czero_r [0:NI];

  logic signed [COR_W-1:0] rot_x, rot_y;

  logic signed [ZW-1:0] wz_r, wz_nxt;
  logic                 wzero_r;
  logic [HW-1:0]        h_sum, h_val;
  logic [14:0]          out_heading_r, out_heading_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      x_min_r <= X_MIN_RST;
      x_max_r <= X_MAX_RST;
      y_min_r <= Y_MIN_RST;
      y_max_r <= Y_MAX_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_X_MIN: x_min_r <= cfg_data;
        CFG_X_MAX: x_max_r <= cfg_data;
        CFG_Y_MIN: y_min_r <= cfg_data;
        CFG_Y_MAX: y_max_r <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  genvar k;
  generate
    for (k = 0; k < NS - 1; k++) begin : g_adv
      assign adv[k] = !valid_r[k] || adv[k + 1];
    end
  endgenerate
  assign adv[NS-1] = !valid_r[NS-1] || out_ready;
  assign in_ready  = adv[0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r[0] <= 1'b0;
    end else if (adv[0]) begin
      valid_r[0] <= in_valid && in_data_ready;
    end
  end

  generate
    for (k = 1; k < NS; k++) begin : g_valid
      always_ff @(posedge clk) begin
        if (!rst_n) begin
          valid_r[k] <= 1'b0;
        end else if (adv[k]) begin
          valid_r[k] <= valid_r[k - 1];
        end
      end
    end
  endgenerate

  // The midpoint truncates toward zero, so odd negative sums round up.
  always_comb begin
    offx_sum = 17'(x_min_r) + 17'(x_max_r);
    offy_sum = 17'(y_min_r) + 17'(y_max_r);
    offx_nxt = (offx_sum + $signed(17'(offx_sum[16]))) >>> 1;
    offy_nxt = (offy_sum + $signed(17'(offy_sum[16]))) >>> 1;
  end

  always_ff @(posedge clk) begin
    if (adv[0]) begin
      s0_x_r    <= in_x_raw;
      s0_y_r    <= in_y_raw;
      s0_offx_r <= offx_nxt;
      s0_offy_r <= offy_nxt;
    end
  end

  always_comb begin
    s1_cx_nxt = COR_W'(s0_x_r) - COR_W'(s0_offx_r);
    s1_cy_nxt = COR_W'(s0_y_r) - COR_W'(s0_offy_r);
  end

  always_ff @(posedge clk) begin
    if (adv[1]) begin
      s1_cx_r   <= s1_cx_nxt;
      s1_cy_r   <= s1_cy_nxt;
      s1_zero_r <= (s1_cx_nxt == '0) && (s1_cy_nxt == '0);
    end
  end

  // Vectors in the left half plane are turned by 180 degrees first.
  always_comb begin
    rot_x = s1_cx_r[COR_W-1] ? -s1_cx_r : s1_cx_r;
    rot_y = s1_cx_r[COR_W-1] ? -s1_cy_r : s1_cy_r;
  end

  always_ff @(posedge clk) begin
    if (adv[2]) begin
      cx_r[0]    <= W'({{3{rot_x[COR_W-1]}}, rot_x, {IN_SCALE{1'b0}}});
      cy_r[0]    <= W'({{3{rot_y[COR_W-1]}}, rot_y, {IN_SCALE{1'b0}}});
      cz_r[0]    <= s1_cx_r[COR_W-1] ? Z_HALF : '0;
      czero_r[0] <= s1_zero_r;
    end
  end

  genvar i;
  generate
    for (i = 0; i < NI; i++) begin : g_cordic
      logic signed [W-1:0] dx, dy;
      logic                up;
      assign dx = cy_r[i] >>> i;
      assign dy = cx_r[i] >>> i;
      assign up = !cy_r[i][W-1] && (cy_r[i] != '0);
      always_ff @(posedge clk) begin
        if (adv[i + 3]) begin
          cx_r[i + 1]    <= up ? cx_r[i] + dx : cx_r[i] - dx;
          cy_r[i + 1]    <= up ? cy_r[i] - dy : cy_r[i] + dy;
          cz_r[i + 1]    <= up ? cz_r[i] + atan_deg_q16(i) : cz_r[i] - atan_deg_q16(i);
          czero_r[i + 1] <= czero_r[i];
        end
      end
    end
  endgenerate

  always_comb begin
    wz_nxt = cz_r[NI];
    if (cz_r[NI][ZW-1]) begin
      wz_nxt = cz_r[NI] + Z_FULL;
    end else if (cz_r[NI] >= Z_FULL) begin
      wz_nxt = cz_r[NI] - Z_FULL;
    end
  end

  always_ff @(posedge clk) begin
    if (adv[ST_WRAP]) begin
      wz_r    <= wz_nxt;
      wzero_r <= czero_r[NI];
    end
  end

  always_comb begin
    h_sum = HW'(unsigned'(wz_r)) + H_ROUND;
    h_val = h_sum >> SH;
    if (wzero_r || (h_val >= H_FULL)) begin
      out_heading_nxt = '0;
    end else begin
      out_heading_nxt = h_val[14:0];
    end
  end

  always_ff @(posedge clk) begin
    if (adv[ST_OUT]) begin
      out_heading_r <= out_heading_nxt;
    end
  end

  assign out_valid   = valid_r[ST_OUT];
  assign out_heading = out_heading_r;

  `CCH_ASSERT_NEXT(a_ready_drop, in_valid && in_ready && !in_data_ready, !valid_r[0])
  `CCH_ASSERT_NEXT(a_ready_take, in_valid && in_ready && in_data_ready, valid_r[0])
  `CCH_ASSERT_NOW(a_stall_full, !in_ready, &valid_r)
  `CCH_ASSERT_NOW(a_wrap_range, valid_r[ST_WRAP], !wz_r[ZW-1] && (wz_r < Z_FULL))
  `CCH_ASSERT_NOW(a_head_range, out_valid && (ANGLE_FRACTION_BITS <= 6), HW'(out_heading) < H_FULL)

endmodule
